### rtl/core/pidsc_pkg.sv
// ----------------------------------------------------------------------------
// pidsc_pkg: shared definitions of the PID speed controller
// Widths, fixed-point constants, register indexes, controller states, the
// command and status words and the saturating helpers of the datapath.
// ----------------------------------------------------------------------------
package pidsc_pkg;

  // Fixed-point format of speeds, gains and internal terms.
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned DATA_WIDTH = 32;

  // Shared multiplier: one spare bit so that unsigned period and rate fit.
  localparam int unsigned OP_WIDTH   = DATA_WIDTH + 1;
  localparam int unsigned PROD_WIDTH = 2 * OP_WIDTH;
  localparam int unsigned ACC_WIDTH  = DATA_WIDTH + 2;

  // Configuration register file.
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned PERIOD_W   = 17;
  localparam int unsigned RATE_W     = 31;

  // Throttle output: Q2.14, limited to plus or minus one.
  localparam int unsigned THR_WIDTH  = 16;
  localparam int unsigned THR_FRAC   = 14;
  localparam int unsigned THR_MAX    = 1 << THR_FRAC;

  // Scaling by 1/100 into Q2.14 is a division by 400, split as 16 times 25.
  // The power of two is a shift; the factor 25 goes by a reciprocal multiply
  // with one correction step.
  localparam int unsigned DIVISOR     = 100 << (FRAC_BITS - THR_FRAC);
  localparam int unsigned DIV_SHIFT   = 4;
  localparam int unsigned DIV_ODD     = DIVISOR >> DIV_SHIFT;
  localparam int unsigned LIMIT_MAG   = DIVISOR * (THR_MAX + 1);
  localparam int unsigned X_WIDTH     = 19;
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned RECIP_WIDTH = 20;
  localparam int unsigned RECIP       = (1 << RECIP_SHIFT) / DIV_ODD;
  localparam int unsigned QM_WIDTH    = X_WIDTH + RECIP_WIDTH;
  localparam int unsigned Q_WIDTH     = QM_WIDTH - RECIP_SHIFT;

  // Register indexes.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_KP,
    REG_KI,
    REG_KD,
    REG_TARGET,
    REG_UPPER,
    REG_LOWER,
    REG_PERIOD,
    REG_RATE
  } reg_idx_e;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_MUL_I,
    S_MUL_D,
    S_MUL_P,
    S_MUL_KI,
    S_MUL_KD,
    S_ACC,
    S_DIV,
    S_OUT
  } state_e;

  // Operand pairs of the shared multiplier.
  typedef enum logic [2:0] {
    MUL_ERR_PERIOD,
    MUL_DIFF_RATE,
    MUL_KP_ERR,
    MUL_KI_INT,
    MUL_KD_DER
  } mul_sel_e;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] kp;
    logic signed [DATA_WIDTH-1:0] ki;
    logic signed [DATA_WIDTH-1:0] kd;
    logic signed [DATA_WIDTH-1:0] target;
    logic signed [DATA_WIDTH-1:0] upper;
    logic signed [DATA_WIDTH-1:0] lower;
    logic [PERIOD_W-1:0]          period;
    logic [RATE_W-1:0]            rate;
    logic                         clear;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_meas;
    logic     calc_err;
    logic     ld_diff;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     upd_integ;
    logic     ld_deriv;
    logic     acc_init;
    logic     acc_add;
    logic     div_prep;
    logic     out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_full;
  } sts_t;

  // Saturate a wide signed value to DATA_WIDTH signed bits.
  function automatic logic signed [DATA_WIDTH-1:0] sat_dw(
    input logic signed [PROD_WIDTH-1:0] x
  );
    logic [PROD_WIDTH-DATA_WIDTH:0] upper_bits;
    logic signed [DATA_WIDTH-1:0]   res;
    upper_bits = x[PROD_WIDTH-1:DATA_WIDTH-1];
    if ((&upper_bits) || (~|upper_bits)) begin
      res = x[DATA_WIDTH-1:0];
    end else if (x[PROD_WIDTH-1]) begin
      res = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      res = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end
    return res;
  endfunction

  // Fixed-point product: drop the fraction bits rounding towards minus
  // infinity, then saturate.
  function automatic logic signed [DATA_WIDTH-1:0] mulq_sat(
    input logic signed [PROD_WIDTH-1:0] p
  );
    logic signed [PROD_WIDTH-1:0] shifted;
    shifted = p >>> FRAC_BITS;
    return sat_dw(shifted);
  endfunction

endpackage

### rtl/core/pidsc_cfg.sv
// ----------------------------------------------------------------------------
// pidsc_cfg: configuration register file
// Holds gains, setpoint, integral limits, sample period and sample rate, and
// flags the writes that restart the integral and the derivative history.
// ----------------------------------------------------------------------------
module pidsc_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pidsc_pkg::REG_IDX_W-1:0]    cfg_index_i,
  input  logic [pidsc_pkg::DATA_WIDTH-1:0]   cfg_data_i,
  output pidsc_pkg::cfg_t                    cfg_o
);

  logic signed [pidsc_pkg::DATA_WIDTH-1:0] kp_q, ki_q, kd_q, target_q, upper_q, lower_q;
  logic [pidsc_pkg::PERIOD_W-1:0]          period_q;
  logic [pidsc_pkg::RATE_W-1:0]            rate_q;

  // Register writes; the reset values give a working controller at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q     <= 32'sd655360;
      ki_q     <= 32'sd65536;
      kd_q     <= 32'sd6554;
      target_q <= 32'sd1310720;
      upper_q  <= 32'sd6553600;
      lower_q  <= -32'sd6553600;
      period_q <= 17'd655;
      rate_q   <= 31'd6553600;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pidsc_pkg::REG_KP:     kp_q     <= cfg_data_i;
        pidsc_pkg::REG_KI:     ki_q     <= cfg_data_i;
        pidsc_pkg::REG_KD:     kd_q     <= cfg_data_i;
        pidsc_pkg::REG_TARGET: target_q <= cfg_data_i;
        pidsc_pkg::REG_UPPER:  upper_q  <= cfg_data_i;
        pidsc_pkg::REG_LOWER:  lower_q  <= cfg_data_i;
        pidsc_pkg::REG_PERIOD: period_q <= cfg_data_i[pidsc_pkg::PERIOD_W-1:0];
        pidsc_pkg::REG_RATE:   rate_q   <= cfg_data_i[pidsc_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // A new gain or setpoint restarts the controller history.
  always_comb begin
    cfg_o.kp     = kp_q;
    cfg_o.ki     = ki_q;
    cfg_o.kd     = kd_q;
    cfg_o.target = target_q;
    cfg_o.upper  = upper_q;
    cfg_o.lower  = lower_q;
    cfg_o.period = period_q;
    cfg_o.rate   = rate_q;
    cfg_o.clear  = cfg_we_i && (cfg_index_i <= pidsc_pkg::REG_TARGET);
  end

endmodule

### rtl/core/pidsc_ctrl.sv
// ----------------------------------------------------------------------------
// pidsc_ctrl: sequencing state machine
// Steps one speed word through error, integral, derivative, the three gain
// products and the throttle scaling, issuing one command word per cycle.
// ----------------------------------------------------------------------------
module pidsc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pidsc_pkg::sts_t   sts_i,
  output pidsc_pkg::cmd_t   cmd_o
);

  pidsc_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pidsc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pidsc_pkg::S_IDLE:   if (in_valid_i) state_d = pidsc_pkg::S_ERR;
      pidsc_pkg::S_ERR:    state_d = pidsc_pkg::S_MUL_I;
      pidsc_pkg::S_MUL_I:  state_d = pidsc_pkg::S_MUL_D;
      pidsc_pkg::S_MUL_D:  state_d = pidsc_pkg::S_MUL_P;
      pidsc_pkg::S_MUL_P:  state_d = pidsc_pkg::S_MUL_KI;
      pidsc_pkg::S_MUL_KI: state_d = pidsc_pkg::S_MUL_KD;
      pidsc_pkg::S_MUL_KD: state_d = pidsc_pkg::S_ACC;
      pidsc_pkg::S_ACC:    state_d = pidsc_pkg::S_DIV;
      pidsc_pkg::S_DIV:    state_d = pidsc_pkg::S_OUT;
      pidsc_pkg::S_OUT:    if (!sts_i.out_full) state_d = pidsc_pkg::S_IDLE;
      default:             state_d = pidsc_pkg::S_IDLE;
    endcase
  end

  // Command word for each step.
  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = pidsc_pkg::MUL_ERR_PERIOD;
    in_stall_o    = 1'b1;
    case (state_q)
      pidsc_pkg::S_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.load_meas = in_valid_i;
      end
      pidsc_pkg::S_ERR: begin
        cmd_o.calc_err = 1'b1;
      end
      pidsc_pkg::S_MUL_I: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pidsc_pkg::MUL_ERR_PERIOD;
        cmd_o.ld_diff = 1'b1;
      end
      pidsc_pkg::S_MUL_D: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_sel   = pidsc_pkg::MUL_DIFF_RATE;
        cmd_o.upd_integ = 1'b1;
      end
      pidsc_pkg::S_MUL_P: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = pidsc_pkg::MUL_KP_ERR;
        cmd_o.ld_deriv = 1'b1;
      end
      pidsc_pkg::S_MUL_KI: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = pidsc_pkg::MUL_KI_INT;
        cmd_o.acc_init = 1'b1;
      end
      pidsc_pkg::S_MUL_KD: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = pidsc_pkg::MUL_KD_DER;
        cmd_o.acc_add = 1'b1;
      end
      pidsc_pkg::S_ACC: begin
        cmd_o.acc_add = 1'b1;
      end
      pidsc_pkg::S_DIV: begin
        cmd_o.div_prep = 1'b1;
      end
      pidsc_pkg::S_OUT: begin
        cmd_o.out_load = !sts_i.out_full;
      end
      default: ;
    endcase
  end

endmodule

### rtl/core/pidsc_dp.sv
// ----------------------------------------------------------------------------
// pidsc_dp: arithmetic datapath
// One shared signed multiplier with a product register, the integral and
// previous-error state, the gain accumulator, the scaling to Q2.14 and the
// output register.
// ----------------------------------------------------------------------------
module pidsc_dp (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  pidsc_pkg::cfg_t                         cfg_i,
  input  pidsc_pkg::cmd_t                         cmd_i,
  output pidsc_pkg::sts_t                         sts_o,
  input  logic signed [pidsc_pkg::DATA_WIDTH-1:0] measured_speed_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [pidsc_pkg::THR_WIDTH-1:0]  throttle_command_o,
  output logic signed [pidsc_pkg::DATA_WIDTH-1:0] speed_error_o,
  output logic                                    throttle_limited_o
);

  localparam int unsigned DW = pidsc_pkg::DATA_WIDTH;
  localparam int unsigned OW = pidsc_pkg::OP_WIDTH;
  localparam int unsigned PW = pidsc_pkg::PROD_WIDTH;
  localparam int unsigned AW = pidsc_pkg::ACC_WIDTH;
  localparam int unsigned XW = pidsc_pkg::X_WIDTH;
  localparam int unsigned QW = pidsc_pkg::Q_WIDTH;
  localparam int unsigned TW = pidsc_pkg::THR_WIDTH;

  // Working registers.
  logic signed [DW-1:0] meas_q, err_q, diff_q, deriv_q;
  logic signed [DW-1:0] integ_q, last_err_q;
  logic signed [PW-1:0] prod_q;
  logic signed [AW-1:0] acc_q;
  logic [XW-1:0]        x_q;
  logic                 neg_q, big_q;
  logic [pidsc_pkg::QM_WIDTH-1:0] qm_q;

  // Output register.
  logic signed [TW-1:0] thr_q;
  logic signed [DW-1:0] err_out_q;
  logic                 lim_q, out_valid_q;

  // Combinational terms.
  logic signed [OW-1:0] op_a, op_b;
  logic signed [DW-1:0] prod_fx, err_c, diff_c, integ_sum, integ_hi, integ_c;
  logic signed [DW-1:0] ctrl_c;
  logic [DW-1:0]        mag_c;
  logic [QW-1:0]        q0_c, q_c;
  logic [XW:0]          rem_c;
  logic signed [TW-1:0] thr_c;

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd_i.mul_sel)
      pidsc_pkg::MUL_ERR_PERIOD: begin
        op_a = OW'(err_q);
        op_b = OW'($signed({1'b0, cfg_i.period}));
      end
      pidsc_pkg::MUL_DIFF_RATE: begin
        op_a = OW'(diff_q);
        op_b = OW'($signed({1'b0, cfg_i.rate}));
      end
      pidsc_pkg::MUL_KP_ERR: begin
        op_a = OW'($signed(cfg_i.kp));
        op_b = OW'(err_q);
      end
      pidsc_pkg::MUL_KI_INT: begin
        op_a = OW'($signed(cfg_i.ki));
        op_b = OW'(integ_q);
      end
      pidsc_pkg::MUL_KD_DER: begin
        op_a = OW'($signed(cfg_i.kd));
        op_b = OW'(deriv_q);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Error, error difference and the clamped integral update.
  always_comb begin
    prod_fx   = pidsc_pkg::mulq_sat(prod_q);
    err_c     = pidsc_pkg::sat_dw(PW'($signed(cfg_i.target)) - PW'(meas_q));
    diff_c    = pidsc_pkg::sat_dw(PW'(err_q) - PW'(last_err_q));
    integ_sum = pidsc_pkg::sat_dw(PW'(integ_q) + PW'(prod_fx));
    integ_hi  = (integ_sum > $signed(cfg_i.upper)) ? $signed(cfg_i.upper) : integ_sum;
    integ_c   = (integ_hi < $signed(cfg_i.lower)) ? $signed(cfg_i.lower) : integ_hi;
  end

  // Control value and its magnitude for the scaling step.
  always_comb begin
    ctrl_c = pidsc_pkg::sat_dw(PW'(acc_q));
    mag_c  = ctrl_c[DW-1] ? DW'(-ctrl_c) : DW'(ctrl_c);
  end

  // Quotient by the odd factor: the reciprocal estimate is exact or one low.
  always_comb begin
    q0_c  = qm_q[pidsc_pkg::QM_WIDTH-1:pidsc_pkg::RECIP_SHIFT];
    rem_c = (XW + 1)'(x_q) - (XW + 1)'(q0_c) * (XW + 1)'(pidsc_pkg::DIV_ODD);
    q_c   = (rem_c >= (XW + 1)'(pidsc_pkg::DIV_ODD)) ? q0_c + QW'(1) : q0_c;
    if (big_q) begin
      thr_c = neg_q ? -TW'(pidsc_pkg::THR_MAX) : TW'(pidsc_pkg::THR_MAX);
    end else begin
      thr_c = neg_q ? -$signed(TW'(q_c)) : $signed(TW'(q_c));
    end
  end

  // Payload registers of the sequence.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_meas) meas_q <= measured_speed_i;
    if (cmd_i.calc_err)  err_q  <= err_c;
    if (cmd_i.ld_diff)   diff_q <= diff_c;
    if (cmd_i.mul_en)    prod_q <= op_a * op_b;
    if (cmd_i.ld_deriv)  deriv_q <= prod_fx;
    if (cmd_i.acc_init) begin
      acc_q <= AW'(prod_fx);
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + AW'(prod_fx);
    end
    if (cmd_i.div_prep) begin
      neg_q <= ctrl_c[DW-1];
      big_q <= (mag_c >= DW'(pidsc_pkg::LIMIT_MAG));
      x_q   <= mag_c[pidsc_pkg::DIV_SHIFT+XW-1:pidsc_pkg::DIV_SHIFT];
      qm_q  <= mag_c[pidsc_pkg::DIV_SHIFT+XW-1:pidsc_pkg::DIV_SHIFT]
               * pidsc_pkg::RECIP_WIDTH'(pidsc_pkg::RECIP);
    end
    if (cmd_i.out_load) begin
      thr_q     <= thr_c;
      err_out_q <= err_q;
      lim_q     <= big_q;
    end
  end

  // Controller history: integral and previous error.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q    <= '0;
      last_err_q <= '0;
    end else if (cfg_i.clear) begin
      integ_q    <= '0;
      last_err_q <= '0;
    end else begin
      if (cmd_i.upd_integ) integ_q    <= integ_c;
      if (cmd_i.ld_deriv)  last_err_q <= err_q;
    end
  end

  // Output word valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.out_load || (out_valid_q && out_stall_i);
    end
  end

  assign sts_o.out_full     = out_valid_q && out_stall_i;
  assign out_valid_o        = out_valid_q;
  assign throttle_command_o = thr_q;
  assign speed_error_o      = err_out_q;
  assign throttle_limited_o = lim_q;

endmodule

### rtl/core/pid_speed_controller.sv
// ----------------------------------------------------------------------------
// pid_speed_controller: fixed-point PID speed controller with integral clamp
// Top level joining the register file, the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Each accepted speed word (signed Q16.16) gives one result word: the throttle
// command in Q2.14 clamped to plus or minus one, the saturated speed error and
// a flag that is set when the throttle was clamped. After acceptance the error
// is formed first, the single shared multiplier then takes five products one
// after another, the last product is added and the scaling follows: the
// reciprocal multiply is registered, then its correction feeds the output
// register. The next word is accepted on the cycle after the result is loaded,
// so no new word is taken while one is being worked on. A result waits in the
// output register while the next word is worked on. Writing a gain or the
// setpoint clears the integral and the previous error; the user must write
// configuration only while the block is idle, as the block does not enforce it.
module pid_speed_controller (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [pidsc_pkg::DATA_WIDTH-1:0] measured_speed_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [pidsc_pkg::THR_WIDTH-1:0]  throttle_command_o,
  output logic signed [pidsc_pkg::DATA_WIDTH-1:0] speed_error_o,
  output logic                                    throttle_limited_o,
  input  logic                                    cfg_we_i,
  input  logic [pidsc_pkg::REG_IDX_W-1:0]         cfg_index_i,
  input  logic [pidsc_pkg::DATA_WIDTH-1:0]        cfg_data_i
);

  pidsc_pkg::cfg_t cfg;
  pidsc_pkg::cmd_t cmd;
  pidsc_pkg::sts_t sts;

  // Configuration registers.
  pidsc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Sequencer.
  pidsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath.
  pidsc_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .measured_speed_i   (measured_speed_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .throttle_command_o (throttle_command_o),
    .speed_error_o      (speed_error_o),
    .throttle_limited_o (throttle_limited_o)
  );

endmodule
